// ===== hw/rtl/monotonic_decreasing_stack_assert.svh =====
// assertion helpers for the monotonic decreasing stack
// both expect clk and rst_n in scope
`ifndef MONOTONIC_DECREASING_STACK_ASSERT_SVH
`define MONOTONIC_DECREASING_STACK_ASSERT_SVH

// same-cycle implication
`define MDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mds_pkg.sv =====
// ----------------------------------------------------------------------------
// mds_pkg
// shared constants, codes and beat types for the monotonic decreasing stack
// ----------------------------------------------------------------------------
package mds_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 7;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] push_value;
    } stk_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [STATUS_W-1:0]       status;
        logic [DEPTH_W-1:0]        depth_now;
        logic [DEPTH_W-1:0]        depth_peak;
        logic                      last;
    } stk_out_t;

endpackage

// ===== hw/rtl/mds_mem.sv =====
// ----------------------------------------------------------------------------
// mds_mem
// entry storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mds_mem #(
    parameter int DEPTH  = mds_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH  = mds_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/monotonic_decreasing_stack.sv =====
// ----------------------------------------------------------------------------
// monotonic_decreasing_stack
// stack of signed words that only accepts strictly decreasing pushes
// ----------------------------------------------------------------------------
// Usage: drive item (mode, push_value) with start high; the beat is taken at
// a rising edge where start is high and busy is low. Every item yields one or
// more result beats on result, each marked by done for exactly one cycle;
// result.last flags the final beat of the item. The receiver cannot stall.
// Push, pop and error or empty results are registered and appear in the
// cycle after the item is taken; list and drain give their first beat only
// after the top entry has come out of the memory read port and then through
// the result register. Push and error or empty results leave the block idle,
// so a new item can be taken at once; a pop that leaves entries behind goes
// through S_REFILL (busy) to reload the cached top entry from the memory read
// port; list and drain stay busy and stream one beat per cycle, paced by the
// single read port of the entry memory with its registered read data.
// Reset clears depth and peak and returns to idle; memory contents are kept
// but never read before being written, so no clearing pass is run.
// ----------------------------------------------------------------------------
`include "monotonic_decreasing_stack_assert.svh"

module monotonic_decreasing_stack #(
    parameter int STACK_DEPTH = mds_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = mds_pkg::DATA_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mds_pkg::stk_in_t item,
    output logic             done,
    output mds_pkg::stk_out_t result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REFILL,
        S_LIST,
        S_DRAIN
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            peak_reg, peak_next;
    logic signed [DATA_WIDTH-1:0] top_reg, top_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic                     done_reg, done_next;
    mds_pkg::stk_out_t        result_reg, result_next;

    logic                     we;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_WIDTH-1:0] push_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_WIDTH-1:0] rd_data;
    logic [CW-1:0]            fill_inc;
    logic [CW-1:0]            fill_dec;
    logic                     accept;

    assign push_data = DATA_WIDTH'(item.push_value);
    assign fill_inc  = fill_reg + CW'(1);
    assign fill_dec  = fill_reg - CW'(1);
    assign accept    = start && (state_reg == S_IDLE);
    assign wr_addr   = fill_reg[AW-1:0];

    mds_mem #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (AW)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (push_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        peak_next   = peak_reg;
        top_next    = top_reg;
        ptr_next    = ptr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next              = 1'b1;
                    result_next.out_value  = '0;
                    result_next.last       = 1'b1;
                    result_next.depth_now  = mds_pkg::DEPTH_W'(fill_reg);
                    result_next.depth_peak = mds_pkg::DEPTH_W'(peak_reg);
                    if (item.mode == mds_pkg::MODE_PUSH)
                    begin
                        if (fill_reg == CW'(STACK_DEPTH))
                        begin
                            result_next.status = mds_pkg::ST_OVERFLOW;
                        end
                        else if (fill_reg != '0 && !(push_data < top_reg))
                        begin
                            result_next.status = mds_pkg::ST_ORDER;
                        end
                        else
                        begin
                            we                    = 1'b1;
                            top_next              = push_data;
                            fill_next             = fill_inc;
                            result_next.status    = mds_pkg::ST_OK;
                            result_next.depth_now = mds_pkg::DEPTH_W'(fill_inc);
                            if (fill_inc > peak_reg)
                            begin
                                peak_next              = fill_inc;
                                result_next.depth_peak = mds_pkg::DEPTH_W'(fill_inc);
                            end
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        result_next.status = mds_pkg::ST_EMPTY;
                    end
                    else if (item.mode == mds_pkg::MODE_POP)
                    begin
                        result_next.status    = mds_pkg::ST_OK;
                        result_next.out_value = mds_pkg::VALUE_W'(top_reg);
                        result_next.depth_now = mds_pkg::DEPTH_W'(fill_dec);
                        fill_next             = fill_dec;
                        // reload the new top from memory
                        if (fill_reg > CW'(1))
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(fill_reg - CW'(2));
                            state_next = S_REFILL;
                        end
                    end
                    else
                    begin
                        // list or drain: prime the read pipe with the top entry
                        done_next = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = AW'(fill_dec);
                        ptr_next  = AW'(fill_dec);
                        state_next = (item.mode == mds_pkg::MODE_LIST) ? S_LIST : S_DRAIN;
                    end
                end
            end
            S_REFILL:
            begin
                top_next   = rd_data;
                state_next = S_IDLE;
            end
            S_LIST, S_DRAIN:
            begin
                done_next              = 1'b1;
                result_next.out_value  = mds_pkg::VALUE_W'(rd_data);
                result_next.status     = mds_pkg::ST_OK;
                result_next.depth_peak = mds_pkg::DEPTH_W'(peak_reg);
                result_next.last       = (ptr_reg == '0);
                if (state_reg == S_DRAIN)
                begin
                    fill_next             = CW'(ptr_reg);
                    result_next.depth_now = mds_pkg::DEPTH_W'(ptr_reg);
                end
                else
                begin
                    result_next.depth_now = mds_pkg::DEPTH_W'(fill_reg);
                end
                if (ptr_reg != '0)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - AW'(1);
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            peak_reg   <= '0;
            done_reg   <= 1'b0;
            top_reg    <= '0;
            ptr_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            peak_reg   <= peak_next;
            done_reg   <= done_next;
            top_reg    <= top_next;
            ptr_reg    <= ptr_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `MDS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CW'(STACK_DEPTH), "fill above depth")
    `MDS_ASSERT_NOW(a_peak_covers_fill, 1'b1, peak_reg >= fill_reg, "peak below fill")
    `MDS_ASSERT_NOW(a_write_idle_only, we, state_reg == S_IDLE && fill_reg < CW'(STACK_DEPTH),
        "write outside idle or when full")
    `MDS_ASSERT_NOW(a_drain_track, state_reg == S_DRAIN, fill_reg == CW'(ptr_reg) + CW'(1),
        "drain pointer out of step with fill")
    `MDS_ASSERT_NEXT(a_refill_returns, state_reg == S_REFILL, state_reg == S_IDLE,
        "top reload did not finish")

endmodule
